[hw/rtl/f2n_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package f2n_pkg;
    localparam int unsigned InWidth  = 64;
    localparam int unsigned OutWidth = 32;
    localparam logic [10:0] Exp64Max = 11'h7FF;
    localparam logic [31:0] Exp32Inf = 32'h7F80_0000;
    localparam logic [31:0] QuietNan = 32'h7FC0_0000;
endpackage
`default_nettype wire

[hw/rtl/f2n_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface f2n_stream_if #(
    parameter int unsigned Width = 32
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/fp64_to_fp32_narrowing_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | payload
// in_chan   | sink      | double_bits [63:0]
// out_chan  | source    | single_bits [31:0]
//
// one transaction per cycle sustained while out_chan is ready; an accepted double is
// held in the input register, then converted and loaded into the result register
// rst_n clears only the valid flags; payload registers are not reset
// in_chan.ready stays high while the input register is empty or moving on,
// so a stall on out_chan backs up through the input register stage
module fp64_to_fp32_narrowing_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    f2n_stream_if.sink   in_chan,
    f2n_stream_if.source out_chan
);
    logic        in_vld_reg;
    logic [63:0] in_data_reg;
    logic        out_vld_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;
    logic        out_load;
    logic        in_take;

    assign out_load = in_vld_reg && (!out_vld_reg || out_chan.ready);
    assign in_take  = !in_vld_reg || out_load;
    assign in_chan.ready  = in_take;
    assign out_chan.valid = out_vld_reg;
    assign out_chan.data  = out_data_reg;

    // conversion datapath
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] man;
    logic signed [12:0] fe;
    logic [5:0]  sh;
    logic [52:0] q;
    logic [53:0] qr;
    logic [63:0] rem_mask;
    logic [63:0] rem;
    logic [63:0] half;
    logic        rnd_up;
    logic [31:0] bits;
    logic [12:0] sub_sh;

    always_comb
    begin
        sgn = in_data_reg[63];
        ex  = in_data_reg[62:52];
        fr  = in_data_reg[51:0];
        man = {1'b1, fr};
        fe  = $signed({2'b00, ex}) - 13'sd896;
        sub_sh = 13'd30 - fe;
        sh  = (fe >= 13'sd1) ? 6'd29 : sub_sh[5:0];
        q        = man >> sh;
        // remainder and half kept wide enough for shifts past the significand
        rem_mask = (64'd1 << sh) - 64'd1;
        rem      = {11'd0, man} & rem_mask;
        half     = 64'd1 << (sh - 6'd1);
        rnd_up   = (rem > half) || ((rem == half) && q[0]);
        qr       = {1'b0, q} + {53'd0, rnd_up};
        if (fe >= 13'sd1)
        begin
            bits = {1'b0, fe[7:0] - 8'd1, 23'd0} + qr[31:0];
        end
        else
        begin
            bits = qr[31:0];
        end
        priority if (ex == f2n_pkg::Exp64Max)
        begin
            out_data_next = (fr == 52'd0) ? ({sgn, 31'd0} | f2n_pkg::Exp32Inf)
                : ({sgn, 31'd0} | f2n_pkg::QuietNan | {10'd0, fr[50:29]});
        end
        else if (ex == 11'd0)
        begin
            out_data_next = {sgn, 31'd0};
        end
        else if (fe >= 13'sd255)
        begin
            out_data_next = {sgn, 31'd0} | f2n_pkg::Exp32Inf;
        end
        else if (fe <= -13'sd31)
        begin
            // shift beyond the significand: always rounds to zero
            out_data_next = {sgn, 31'd0};
        end
        else if (bits >= f2n_pkg::Exp32Inf)
        begin
            out_data_next = {sgn, 31'd0} | f2n_pkg::Exp32Inf;
        end
        else
        begin
            out_data_next = {sgn, bits[30:0]};
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= in_chan.valid;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take && in_chan.valid)
        begin
            in_data_reg <= in_chan.data;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/f2n_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module f2n_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // an empty result register means the input side is open
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");
    // an accepted transaction yields a result via the input and result registers while the output stays ready
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
        else $error("result missing");
    // nothing comes out of an empty pipe
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && in_ready ##1 !out_valid |=> !out_valid)
        else $error("invented result");
endmodule

bind fp64_to_fp32_narrowing_unit f2n_checker u_f2n_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
);
`default_nettype wire

[tb/fp64_to_fp32_narrowing_unit_tb.sv]
`timescale 1ns / 1ps
module fp64_to_fp32_narrowing_unit_tb;
    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 8;

    // idling modes
    typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

    logic clk;
    logic rst_n;

    f2n_stream_if #(.Width(f2n_pkg::InWidth))  in_chan ();
    f2n_stream_if #(.Width(f2n_pkg::OutWidth)) out_chan ();

    fp64_to_fp32_narrowing_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    logic [f2n_pkg::OutWidth-1:0] expected_singles[$];
    int                  mismatches;
    int                  sent_count;
    int                  checked_count;
    int                  idle_cycles;
    idle_mode_t          idle_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rounded double to single conversion, round to nearest even
    function automatic logic [31:0] narrow_double(input logic [63:0] x);
        logic [31:0]  sgn;
        logic [10:0]  ex;
        logic [51:0]  fr;
        logic [63:0]  mant;
        logic [63:0]  quo;
        logic [63:0]  rem;
        logic [63:0]  half;
        logic [63:0]  packed_bits;
        int           fexp;
        int unsigned  shamt;
        sgn  = {x[63], 31'b0};
        ex   = x[62:52];
        fr   = x[51:0];
        if (ex == f2n_pkg::Exp64Max)
        begin
            if (fr == 0)
                return sgn | f2n_pkg::Exp32Inf;
            return sgn | f2n_pkg::QuietNan | 32'(fr >> 29);
        end
        if (ex == 0)
            return sgn;
        mant = {12'b1, fr};
        fexp = int'(ex) - 1023 + 127;
        if (fexp >= 255)
            return sgn | f2n_pkg::Exp32Inf;
        if (fexp >= 1)
            shamt = 29;
        else if (fexp > -40)
            shamt = 30 - fexp;
        else
            return sgn;
        if (shamt > 60)
            return sgn;
        quo  = mant >> shamt;
        rem  = mant & ((64'd1 << shamt) - 1);
        half = 64'd1 << (shamt - 1);
        if (rem > half || (rem == half && quo[0]))
            quo = quo + 1;
        if (fexp >= 1)
            packed_bits = (64'(fexp - 1) << 23) + quo;
        else
            packed_bits = quo;
        if (packed_bits >= 64'(f2n_pkg::Exp32Inf))
            return sgn | f2n_pkg::Exp32Inf;
        return sgn | packed_bits[31:0];
    endfunction

    function automatic bit idle_now(input bit for_sender);
        case (idle_mode)
            IdleSender:   return for_sender && ($urandom_range(99) < 83);
            IdleReceiver: return !for_sender && ($urandom_range(99) < 83);
            IdleBoth:     return $urandom_range(99) < 6;
            default:      return 1'b0;
        endcase
    endfunction

    // receiver ready, changed at falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_chan.ready <= 1'b0;
        else
            out_chan.ready <= !idle_now(1'b0);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_singles.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %h", $time, out_chan.data);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    if (out_chan.data !== expected_singles[0])
                    begin
                        $display("%0t: single_bits mismatch, expected %h actual %h",
                                 $time, expected_singles[0], out_chan.data);
                        mismatches <= mismatches + 1;
                    end
                    void'(expected_singles.pop_front());
                end
            end
            if ((out_chan.valid && out_chan.ready) || (in_chan.valid && in_chan.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("%0t: watchdog expired, %0d transactions outstanding",
                         $time, expected_singles.size());
                $display("fp64_to_fp32_narrowing_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // send one double, with sender idling
    task automatic send_double(input logic [63:0] value);
        while (idle_now(1'b1))
        begin
            in_chan.valid <= 1'b0;
            @(negedge clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.data  <= value;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        expected_singles.push_back(narrow_double(value));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        in_chan.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (expected_singles.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // random double built around a chosen exponent
    function automatic logic [63:0] random_double();
        logic [10:0] ex;
        logic [51:0] fr;
        int          pick;
        pick = $urandom_range(99);
        fr   = 52'({$urandom, $urandom});
        if (pick < 40)
            ex = 11'($urandom_range(1023 + 127, 1023 - 126));
        else if (pick < 60)
            ex = 11'($urandom_range(1023 - 126, 1023 - 152));
        else if (pick < 70)
            ex = 11'($urandom_range(1023 + 129, 1023 + 126));
        else if (pick < 78)
        begin
            ex = 11'($urandom_range(1023 + 128, 1023 - 152));
            // force ties and near ties in the rounding bits
            fr[28:0] = ($urandom_range(1)) ? 29'h1000_0000 : 29'h0FFF_FFFF;
        end
        else if (pick < 84)
            ex = f2n_pkg::Exp64Max;
        else if (pick < 88)
            ex = 11'd0;
        else
            ex = 11'($urandom);
        if ($urandom_range(9) == 0)
            fr = ($urandom_range(1)) ? '0 : '1;
        return {1'($urandom), ex, fr};
    endfunction

    task automatic test_special_values();
        send_double(64'h0000_0000_0000_0000);
        send_double(64'h8000_0000_0000_0000);
        send_double(64'h0000_0000_0000_0001);
        send_double(64'h800F_FFFF_FFFF_FFFF);
        send_double(64'h7FF0_0000_0000_0000);
        send_double(64'hFFF0_0000_0000_0000);
        send_double(64'h7FF8_0000_0000_0000);
        send_double(64'hFFF0_0000_2000_0000);
        send_double(64'h7FFF_FFFF_FFFF_FFFF);
        send_double(64'h7FF0_0000_0000_0001);
        send_double(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_rounding_edges();
        send_double(64'h3FF0_0000_0000_0000); // one
        send_double(64'h3FF0_0000_1000_0000); // tie to even, down
        send_double(64'h3FF0_0000_3000_0000); // tie to even, up
        send_double(64'h3FF0_0000_1000_0001); // just above half
        send_double(64'h47EF_FFFF_E000_0000); // float max
        send_double(64'h47EF_FFFF_F000_0000); // rounds to infinity
        send_double(64'hC7F0_0000_0000_0000); // overflow
        send_double(64'h3810_0000_0000_0000); // smallest normal
        send_double(64'h380F_FFFF_F000_0000); // rounds up to smallest normal
        send_double(64'h36A0_0000_0000_0000); // smallest subnormal
        send_double(64'h3690_0000_0000_0000); // half of it, ties to zero
        send_double(64'hB690_0000_0000_0001); // just above half
        send_double(64'h3680_0000_0000_0000); // underflow to zero
        send_double(64'h7FEF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_random_phase(input idle_mode_t mode, input int count);
        idle_mode = mode;
        repeat (count) send_double(random_double());
    endtask

    task automatic test_paused_sender();
        repeat (20) send_double(random_double());
        wait_drained();
        repeat (20) send_double(random_double());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_chan.valid  = 1'b0;
        in_chan.data   = '0;
        out_chan.ready = 1'b0;
        mismatches     = 0;
        sent_count     = 0;
        checked_count  = 0;
        idle_cycles    = 0;
        idle_mode      = IdleNone;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_values();
        test_rounding_edges();
        test_random_phase(IdleNone, 450);
        test_random_phase(IdleSender, 350);
        test_random_phase(IdleReceiver, 350);
        test_random_phase(IdleBoth, 350);
        test_random_phase(IdleNone, 150);
        test_paused_sender();
        wait_drained();

        $display("converted %0d doubles (specials, rounding ties, subnormals, overflow)",
                 checked_count);
        $display("under four idling modes with %0d mismatches", mismatches);
        if (mismatches == 0 && sent_count == checked_count)
            $display("fp64_to_fp32_narrowing_unit_tb: PASS");
        else
            $display("fp64_to_fp32_narrowing_unit_tb: FAIL");
        $finish;
    end
endmodule
